FILE: hw/rtl/ac3hp_pkg.sv
// shared types, constants and table functions for the ac3 sync header parser
package ac3hp_pkg;

  typedef enum logic [1:0] {
    PH_START  = 2'd0,
    PH_HUNT   = 2'd1,
    PH_HEADER = 2'd2,
    PH_FRAME  = 2'd3
  } phase_t;

  localparam logic [7:0] SYNC_HI     = 8'h0B;
  localparam logic [7:0] SYNC_LO     = 8'h77;
  localparam int         HEADER_LEN  = 6;
  localparam logic [2:0] HDR_LAST    = 3'(HEADER_LEN - 1);
  localparam logic [5:0] FSIZE_LIMIT = 6'd38;
  localparam logic [1:0] FS_48K      = 2'd0;
  localparam logic [1:0] FS_44K      = 2'd1;
  localparam logic [1:0] FS_32K      = 2'd2;
  localparam logic [1:0] FS_RESERVED = 2'd3;
  localparam logic [2:0] ACMOD_1_0   = 3'd1;
  localparam logic [2:0] ACMOD_2_0   = 3'd2;
  localparam int         NUM_RATES   = 19;
  localparam int         FIELD_BITS  = 89;

  localparam logic [9:0] RATE_TAB [NUM_RATES] = '{
    10'd32, 10'd40, 10'd48, 10'd56, 10'd64, 10'd80, 10'd96, 10'd112, 10'd128, 10'd160,
    10'd192, 10'd224, 10'd256, 10'd320, 10'd384, 10'd448, 10'd512, 10'd576, 10'd640
  };

  localparam logic [10:0] WORDS44_TAB [NUM_RATES] = '{
    11'd69, 11'd87, 11'd104, 11'd121, 11'd139, 11'd174, 11'd208, 11'd243, 11'd278,
    11'd348, 11'd417, 11'd487, 11'd557, 11'd696, 11'd835, 11'd975, 11'd1114,
    11'd1253, 11'd1393
  };

  typedef struct packed {
    logic [15:0] crc_word;
    logic [1:0]  sample_rate_code;
    logic [5:0]  frame_size_code;
    logic [10:0] frame_words;
    logic [9:0]  bit_rate_kbps;
    logic [4:0]  stream_id;
    logic [2:0]  service_mode;
    logic [2:0]  channel_mode;
    logic        lfe_on;
    logic        size_valid;
  } hdr_rec_t;

  function automatic logic [9:0] rate_lookup(input logic [5:0] fsize);
    logic [9:0] r;
    r = 10'd0;
    if (fsize < FSIZE_LIMIT) begin
      r = RATE_TAB[fsize[5:1]];
    end
    return r;
  endfunction

  function automatic logic [10:0] words_lookup(input logic [1:0] fscod, input logic [5:0] fsize);
    logic [10:0] rate_w;
    logic [10:0] w;
    rate_w = 11'(rate_lookup(fsize));
    w = 11'd0;
    if (fsize < FSIZE_LIMIT) begin
      case (fscod)
        FS_48K:  w = rate_w << 1;
        FS_44K:  w = WORDS44_TAB[fsize[5:1]] + 11'(fsize[0]);
        FS_32K:  w = rate_w + (rate_w << 1);
        default: w = 11'd0;
      endcase
    end
    return w;
  endfunction

endpackage

FILE: hw/rtl/ac3_sync_header_parser_core.sv
// ac3 sync frame header parser top level, byte stream in, header records out
//
//  channel  dir  handshake           payload
//  in_      in   tvalid/tready       tdata[7:0] stream byte
//  out_     out  tvalid/tready       tdata header record, tuser size_valid
//  cfg_     in   wr_en, no wait      wr_data[31:0] start_skip
//
//  one byte per cycle while in_tready is high; each record is registered
//  reset clears the phase to start skip, all counters and both output slots
//  an output register plus one skid slot; in_tready drops only when both hold records
//  a record needs eight bytes or more; input stalls only if out stalls until the next record
module ac3_sync_header_parser_core #(
  parameter int OFFSET_WIDTH = 40
) (
  input  logic clk,
  input  logic rst_n,

  input  logic [7:0] in_tdata,  // data_byte
  input  logic       in_tvalid,
  output logic       in_tready,

  // header_offset, crc_word, sample_rate_code, frame_size_code, frame_words,
  // bit_rate_kbps, stream_id, service_mode, channel_mode, lfe_on, frame_number
  output logic [((OFFSET_WIDTH + ac3hp_pkg::FIELD_BITS + 7) / 8) * 8 - 1:0] out_tdata,
  output logic [0:0] out_tuser,  // size_valid
  output logic       out_tvalid,
  input  logic       out_tready,

  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data
);

  localparam int REC_W   = OFFSET_WIDTH + ac3hp_pkg::FIELD_BITS;
  localparam int TDATA_W = ((REC_W + 7) / 8) * 8;

  ac3hp_pkg::phase_t phase_r, phase_nxt;
  logic [31:0]             start_skip_r;
  logic [7:0]              prev_r, prev_nxt;
  logic                    prev_valid_r, prev_valid_nxt;
  logic [7:0]              hdr_r [ac3hp_pkg::HEADER_LEN - 1];
  logic [2:0]              hdr_cnt_r, hdr_cnt_nxt;
  logic [11:0]             skip_r, skip_nxt;
  logic [OFFSET_WIDTH-1:0] offset_r;
  logic [31:0]             frames_r, frames_nxt;

  logic [TDATA_W-1:0] out_data_r, skid_data_r, rec_data;
  logic               out_user_r, skid_user_r;
  logic               out_valid_r, skid_valid_r;

  logic                in_fire, start_go, sync_hit, hdr_last, produce, out_free;
  logic [7:0]          hdr_bytes [ac3hp_pkg::HEADER_LEN];
  ac3hp_pkg::hdr_rec_t rec;

  assign in_tready = !skid_valid_r;
  assign in_fire   = in_tvalid && in_tready;
  assign start_go  = offset_r >= OFFSET_WIDTH'(start_skip_r);
  assign sync_hit  = prev_valid_r && (prev_r == ac3hp_pkg::SYNC_HI)
                     && (in_tdata == ac3hp_pkg::SYNC_LO);
  assign hdr_last  = (hdr_cnt_r == ac3hp_pkg::HDR_LAST);
  assign produce   = in_fire && (phase_r == ac3hp_pkg::PH_HEADER) && hdr_last;

  always_comb begin
    for (int i = 0; i < ac3hp_pkg::HEADER_LEN - 1; i++) begin
      hdr_bytes[i] = hdr_r[i];
    end
    hdr_bytes[ac3hp_pkg::HEADER_LEN - 1] = in_tdata;
  end

  ac3hp_decode u_decode (
    .hdr_bytes (hdr_bytes),
    .rec       (rec)
  );

  assign rec_data = TDATA_W'({frames_r, rec.lfe_on, rec.channel_mode, rec.service_mode,
                              rec.stream_id, rec.bit_rate_kbps, rec.frame_words,
                              rec.frame_size_code, rec.sample_rate_code, rec.crc_word,
                              offset_r - OFFSET_WIDTH'(7)});

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (in_fire) begin
      case (phase_r)
        ac3hp_pkg::PH_START: begin
          if (start_go) phase_nxt = ac3hp_pkg::PH_HUNT;
        end
        ac3hp_pkg::PH_HUNT: begin
          if (sync_hit) phase_nxt = ac3hp_pkg::PH_HEADER;
        end
        ac3hp_pkg::PH_HEADER: begin
          if (hdr_last) begin
            phase_nxt = rec.size_valid ? ac3hp_pkg::PH_FRAME : ac3hp_pkg::PH_HUNT;
          end
        end
        ac3hp_pkg::PH_FRAME: begin
          if (skip_r == 12'd1) phase_nxt = ac3hp_pkg::PH_HUNT;
        end
        default: phase_nxt = ac3hp_pkg::PH_START;
      endcase
    end
  end

  // per-phase register updates
  always_comb begin
    prev_nxt       = prev_r;
    prev_valid_nxt = prev_valid_r;
    hdr_cnt_nxt    = hdr_cnt_r;
    skip_nxt       = skip_r;
    frames_nxt     = frames_r;
    if (in_fire) begin
      case (phase_r)
        ac3hp_pkg::PH_START: begin
          if (start_go) begin
            prev_nxt       = in_tdata;
            prev_valid_nxt = 1'b1;
          end
        end
        ac3hp_pkg::PH_HUNT: begin
          if (sync_hit) begin
            hdr_cnt_nxt = 3'd0;
          end else begin
            prev_nxt       = in_tdata;
            prev_valid_nxt = 1'b1;
          end
        end
        ac3hp_pkg::PH_HEADER: begin
          hdr_cnt_nxt = hdr_cnt_r + 3'd1;
          if (hdr_last) begin
            frames_nxt = frames_r + 32'd1;
            if (rec.size_valid) begin
              skip_nxt = {rec.frame_words, 1'b0} - 12'd8;
            end else begin
              prev_nxt       = 8'd0;
              prev_valid_nxt = 1'b0;
            end
          end
        end
        ac3hp_pkg::PH_FRAME: begin
          skip_nxt = skip_r - 12'd1;
          if (skip_r == 12'd1) begin
            prev_nxt       = 8'd0;
            prev_valid_nxt = 1'b0;
          end
        end
        default: begin
          prev_valid_nxt = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= ac3hp_pkg::PH_START;
      start_skip_r <= 32'd0;
      prev_r       <= 8'd0;
      prev_valid_r <= 1'b0;
      hdr_cnt_r    <= 3'd0;
      skip_r       <= 12'd0;
      offset_r     <= '0;
      frames_r     <= 32'd0;
    end else begin
      phase_r      <= phase_nxt;
      prev_r       <= prev_nxt;
      prev_valid_r <= prev_valid_nxt;
      hdr_cnt_r    <= hdr_cnt_nxt;
      skip_r       <= skip_nxt;
      frames_r     <= frames_nxt;
      if (cfg_wr_en) start_skip_r <= cfg_wr_data;
      if (in_fire) offset_r <= offset_r + OFFSET_WIDTH'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && (phase_r == ac3hp_pkg::PH_HEADER) && !hdr_last) begin
      hdr_r[hdr_cnt_r] <= in_tdata;
    end
  end

  // output register with one skid slot
  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid_r  <= skid_valid_r || produce;
        skid_valid_r <= 1'b0;
      end else if (produce) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid_r) begin
        out_data_r <= skid_data_r;
        out_user_r <= skid_user_r;
      end else if (produce) begin
        out_data_r <= rec_data;
        out_user_r <= rec.size_valid;
      end
    end else if (produce) begin
      skid_data_r <= rec_data;
      skid_user_r <= rec.size_valid;
    end
  end

  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tvalid = out_valid_r;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid slot full while output register empty");

  a_frame_skip_live: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == ac3hp_pkg::PH_FRAME) |-> (skip_r != 12'd0))
    else $error("frame skip phase with zero count");

  a_hdr_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == ac3hp_pkg::PH_HEADER) |-> (hdr_cnt_r <= ac3hp_pkg::HDR_LAST))
    else $error("header count past last header byte");

  a_frame_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    produce |=> (frames_r == $past(frames_r) + 32'd1))
    else $error("frame count not advanced by record");

  a_record_lands: assert property (@(posedge clk) disable iff (!rst_n)
    produce |=> out_valid_r)
    else $error("record lost after header capture");

endmodule

FILE: hw/rtl/ac3hp_decode.sv
// field decode of the six header bytes (five captured plus the live one) into one header record
module ac3hp_decode (
  input  logic [7:0]          hdr_bytes [ac3hp_pkg::HEADER_LEN],
  output ac3hp_pkg::hdr_rec_t rec
);

  logic [1:0]  fscod;
  logic [5:0]  fsize;
  logic [2:0]  acmod;
  logic [3:0]  shift;
  logic [15:0] mix_bits;

  assign fscod = hdr_bytes[2][7:6];
  assign fsize = hdr_bytes[2][5:0];
  assign acmod = hdr_bytes[4][7:5];

  // lfeon sits after cmixlev, surmixlev and dsurmod when present
  always_comb begin
    shift = 4'd3;
    if (acmod[0] && (acmod != ac3hp_pkg::ACMOD_1_0)) begin
      shift = shift + 4'd2;
    end
    if (acmod[2]) begin
      shift = shift + 4'd2;
    end
    if (acmod == ac3hp_pkg::ACMOD_2_0) begin
      shift = shift + 4'd2;
    end
  end

  assign mix_bits = {hdr_bytes[4], hdr_bytes[5]} << shift;

  always_comb begin
    rec.crc_word         = {hdr_bytes[0], hdr_bytes[1]};
    rec.sample_rate_code = fscod;
    rec.frame_size_code  = fsize;
    rec.frame_words      = ac3hp_pkg::words_lookup(fscod, fsize);
    rec.bit_rate_kbps    = ac3hp_pkg::rate_lookup(fsize);
    rec.stream_id        = hdr_bytes[3][7:3];
    rec.service_mode     = hdr_bytes[3][2:0];
    rec.channel_mode     = acmod;
    rec.lfe_on           = mix_bits[15];
    rec.size_valid       = (fscod != ac3hp_pkg::FS_RESERVED)
                           && (fsize < ac3hp_pkg::FSIZE_LIMIT);
  end

endmodule

FILE: bench/ac3_sync_header_parser_core_tb.sv
// testbench for the ac3 sync header parser: byte stream in, header records checked field by field
module ac3_sync_header_parser_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int OFFSET_W = 40;
  localparam int TDATA_W = ((OFFSET_W + ac3hp_pkg::FIELD_BITS + 7) / 8) * 8;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 8;

  localparam logic [9:0] KBPS_BY_PAIR [19] = '{
    10'd32, 10'd40, 10'd48, 10'd56, 10'd64, 10'd80, 10'd96, 10'd112, 10'd128, 10'd160,
    10'd192, 10'd224, 10'd256, 10'd320, 10'd384, 10'd448, 10'd512, 10'd576, 10'd640
  };

  localparam logic [10:0] WORDS_BY_FS [3][38] = '{
    '{11'd64, 11'd64, 11'd80, 11'd80, 11'd96, 11'd96, 11'd112, 11'd112, 11'd128, 11'd128,
      11'd160, 11'd160, 11'd192, 11'd192, 11'd224, 11'd224, 11'd256, 11'd256, 11'd320,
      11'd320, 11'd384, 11'd384, 11'd448, 11'd448, 11'd512, 11'd512, 11'd640, 11'd640,
      11'd768, 11'd768, 11'd896, 11'd896, 11'd1024, 11'd1024, 11'd1152, 11'd1152,
      11'd1280, 11'd1280},
    '{11'd69, 11'd70, 11'd87, 11'd88, 11'd104, 11'd105, 11'd121, 11'd122, 11'd139, 11'd140,
      11'd174, 11'd175, 11'd208, 11'd209, 11'd243, 11'd244, 11'd278, 11'd279, 11'd348,
      11'd349, 11'd417, 11'd418, 11'd487, 11'd488, 11'd557, 11'd558, 11'd696, 11'd697,
      11'd835, 11'd836, 11'd975, 11'd976, 11'd1114, 11'd1115, 11'd1253, 11'd1254,
      11'd1393, 11'd1394},
    '{11'd96, 11'd96, 11'd120, 11'd120, 11'd144, 11'd144, 11'd168, 11'd168, 11'd192, 11'd192,
      11'd240, 11'd240, 11'd288, 11'd288, 11'd336, 11'd336, 11'd384, 11'd384, 11'd480,
      11'd480, 11'd576, 11'd576, 11'd672, 11'd672, 11'd768, 11'd768, 11'd960, 11'd960,
      11'd1152, 11'd1152, 11'd1344, 11'd1344, 11'd1536, 11'd1536, 11'd1728, 11'd1728,
      11'd1920, 11'd1920}
  };

  typedef struct packed {
    logic        size_valid;
    logic [6:0]  pad;
    logic [31:0] frame_number;
    logic        lfe_on;
    logic [2:0]  channel_mode;
    logic [2:0]  service_mode;
    logic [4:0]  stream_id;
    logic [9:0]  bit_rate_kbps;
    logic [10:0] frame_words;
    logic [5:0]  frame_size_code;
    logic [1:0]  sample_rate_code;
    logic [15:0] crc_word;
    logic [39:0] header_offset;
  } header_rec_t;

  logic               clk;
  logic               rst_n = 1'b0;
  logic [7:0]         in_tdata = 8'h00;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [TDATA_W-1:0] out_tdata;
  logic [0:0]         out_tuser;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic               cfg_wr_en = 1'b0;
  logic [31:0]        cfg_wr_data = 32'h0;

  ac3hp_pkg::phase_t   parse_state;
  logic [7:0]          last_byte;
  logic                last_byte_ok;
  logic [7:0]          hdr_store [ac3hp_pkg::HEADER_LEN];
  logic [2:0]          hdr_fill;
  logic [31:0]         body_left;
  logic [OFFSET_W-1:0] stream_pos;
  logic [31:0]         frames_made;
  logic [31:0]         skip_limit;

  header_rec_t headers_due [$];
  logic [7:0]  byte_queue [$];

  int   send_idle_pct = 0;
  int   stall_pct = 0;
  logic hold_request = 1'b0;
  logic rx_hold = 1'b0;
  int   mismatches = 0;
  int   records_seen = 0;
  int   bytes_pushed = 0;
  int   bytes_taken = 0;
  int   counted_bytes = 0;
  int   frames_built = 0;
  int   skip_settings = 0;

  ac3_sync_header_parser_core #(
    .OFFSET_WIDTH(OFFSET_W)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  function automatic logic [10:0] frame_words_of(input logic [7:0] code_byte);
    if (code_byte[7:6] == ac3hp_pkg::FS_RESERVED || code_byte[5:0] >= ac3hp_pkg::FSIZE_LIMIT) begin
      return 11'd0;
    end
    return WORDS_BY_FS[code_byte[7:6]][code_byte[5:0]];
  endfunction

  task automatic clear_parser();
    parse_state = ac3hp_pkg::PH_START;
    last_byte = 8'h00;
    last_byte_ok = 1'b0;
    for (int i = 0; i < ac3hp_pkg::HEADER_LEN; i++) hdr_store[i] = 8'h00;
    hdr_fill = 3'd0;
    body_left = 32'd0;
    stream_pos = '0;
    frames_made = 32'd0;
    skip_limit = 32'd0;
  endtask

  task automatic restart_hunt();
    parse_state = ac3hp_pkg::PH_HUNT;
    last_byte = 8'h00;
    last_byte_ok = 1'b0;
  endtask

  task automatic hunt_sync(input logic [7:0] b);
    if (last_byte_ok && last_byte == ac3hp_pkg::SYNC_HI && b == ac3hp_pkg::SYNC_LO) begin
      parse_state = ac3hp_pkg::PH_HEADER;
      hdr_fill = 3'd0;
    end else begin
      last_byte = b;
      last_byte_ok = 1'b1;
    end
  endtask

  task automatic finish_header();
    header_rec_t rec;
    logic [2:0]  acmod;
    logic [15:0] mix;
    int          shift;
    acmod = hdr_store[4][7:5];
    // lfeon sits behind whichever mix level fields this channel mode carries
    shift = 3;
    if (acmod[0] && acmod != ac3hp_pkg::ACMOD_1_0) shift += 2;
    if (acmod[2]) shift += 2;
    if (acmod == ac3hp_pkg::ACMOD_2_0) shift += 2;
    mix = {hdr_store[4], hdr_store[5]} << shift;
    rec = '0;
    rec.size_valid = (hdr_store[2][7:6] != ac3hp_pkg::FS_RESERVED)
                     && (hdr_store[2][5:0] < ac3hp_pkg::FSIZE_LIMIT);
    rec.frame_number = frames_made;
    rec.lfe_on = mix[15];
    rec.channel_mode = acmod;
    rec.service_mode = hdr_store[3][2:0];
    rec.stream_id = hdr_store[3][7:3];
    if (hdr_store[2][5:0] < ac3hp_pkg::FSIZE_LIMIT) begin
      rec.bit_rate_kbps = KBPS_BY_PAIR[hdr_store[2][5:1]];
    end
    rec.frame_words = frame_words_of(hdr_store[2]);
    rec.frame_size_code = hdr_store[2][5:0];
    rec.sample_rate_code = hdr_store[2][7:6];
    rec.crc_word = {hdr_store[0], hdr_store[1]};
    rec.header_offset = stream_pos - 7;
    headers_due.push_back(rec);
    frames_made++;
    if (rec.frame_words >= 11'd5) begin
      body_left = {rec.frame_words, 1'b0} - 32'd8;
      parse_state = ac3hp_pkg::PH_FRAME;
    end else begin
      restart_hunt();
    end
  endtask

  task automatic parse_byte(input logic [7:0] b);
    case (parse_state)
      ac3hp_pkg::PH_START: begin
        if (stream_pos >= OFFSET_W'(skip_limit)) begin
          restart_hunt();
          hunt_sync(b);
        end
      end
      ac3hp_pkg::PH_HUNT: hunt_sync(b);
      ac3hp_pkg::PH_HEADER: begin
        hdr_store[hdr_fill] = b;
        hdr_fill++;
        if (hdr_fill == ac3hp_pkg::HEADER_LEN) finish_header();
      end
      default: begin
        if (body_left != 0) body_left--;
        if (body_left == 0) restart_hunt();
      end
    endcase
    stream_pos++;
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("record %0d %s: expected 0x%0h, got 0x%0h", records_seen, name, want, got);
      end
    end
  endtask

  task automatic check_record(input header_rec_t got);
    header_rec_t want;
    records_seen++;
    if (headers_due.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("record %0d arrived with none pending, offset 0x%0h", records_seen,
                 got.header_offset);
      end
      return;
    end
    want = headers_due.pop_front();
    check_field("header_offset", want.header_offset, got.header_offset);
    check_field("crc_word", want.crc_word, got.crc_word);
    check_field("sample_rate_code", want.sample_rate_code, got.sample_rate_code);
    check_field("frame_size_code", want.frame_size_code, got.frame_size_code);
    check_field("frame_words", want.frame_words, got.frame_words);
    check_field("bit_rate_kbps", want.bit_rate_kbps, got.bit_rate_kbps);
    check_field("stream_id", want.stream_id, got.stream_id);
    check_field("service_mode", want.service_mode, got.service_mode);
    check_field("channel_mode", want.channel_mode, got.channel_mode);
    check_field("lfe_on", want.lfe_on, got.lfe_on);
    check_field("frame_number", want.frame_number, got.frame_number);
    check_field("tdata padding", want.pad, got.pad);
    check_field("size_valid", want.size_valid, got.size_valid);
  endtask

  // input driver and predictor
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      clear_parser();
    end else begin
      if (cfg_wr_en) skip_limit = cfg_wr_data;
      if (in_tvalid && in_tready) begin
        parse_byte(in_tdata);
        bytes_taken++;
      end
      if (!in_tvalid || in_tready) begin
        if (byte_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_tdata <= byte_queue.pop_front();
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // output monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= !rx_hold && ($urandom_range(99) >= stall_pct);
      if (out_tvalid && out_tready) check_record({out_tuser[0], out_tdata});
    end
  end

  initial begin : rx_hold_off
    wait (hold_request);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  task automatic push_byte(input logic [7:0] b, input bit counted);
    byte_queue.push_back(b);
    bytes_pushed++;
    if (counted) counted_bytes++;
  endtask

  // sync word, six header bytes, then for a valid size code the frame body cut short by trim bytes
  task automatic push_frame(input logic [47:0] hdr, input int trim);
    logic [10:0] words;
    int          body;
    words = frame_words_of(hdr[31:24]);
    push_byte(ac3hp_pkg::SYNC_HI, 1'b1);
    push_byte(ac3hp_pkg::SYNC_LO, 1'b1);
    for (int i = 5; i >= 0; i--) push_byte(hdr[i*8 +: 8], 1'b1);
    if (words >= 11'd5) begin
      body = 2 * int'(words) - 8 - trim;
      repeat (body) push_byte(8'($urandom), 1'b1);
    end
    frames_built++;
  endtask

  task automatic push_random_sequence();
    int         pick;
    int         n;
    logic [7:0] code;
    logic [7:0] b;
    pick = $urandom_range(99);
    if (pick < 80) begin
      code = 8'($urandom);
      if ($urandom_range(1) == 1) code[7:6] = ac3hp_pkg::FS_RESERVED;
      else code[5:0] = 6'($urandom_range(63, 38));
      push_frame({16'($urandom), code, 24'($urandom)}, 0);
    end else if (pick < 83) begin
      code = {2'($urandom_range(2)), 6'($urandom_range(1))};
      push_frame({16'($urandom), code, 24'($urandom)}, 0);
    end else if (pick < 96) begin
      n = $urandom_range(10, 1);
      repeat (n) begin
        case ($urandom_range(9))
          0: b = ac3hp_pkg::SYNC_HI;
          1: b = ac3hp_pkg::SYNC_LO;
          default: b = 8'($urandom);
        endcase
        push_byte(b, 1'b1);
      end
    end else begin
      // short body: the next sync word falls inside the skip
      code = {2'($urandom_range(2)), 6'($urandom_range(3))};
      push_frame({16'($urandom), code, 24'($urandom)}, $urandom_range(40, 1));
    end
  endtask

  task automatic wait_idle();
    @(posedge clk);
    while (bytes_taken != bytes_pushed || headers_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_start_skip(input logic [31:0] value);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    skip_settings++;
  endtask

  initial begin : stimulus
    int          word_goal;
    int          frame_goal;
    logic [31:0] skip_values [5];
    skip_values = '{32'd0, 32'd0, 32'h8000_0000, 32'hFFFF_FFFF, 32'd0};
    skip_values[4] = $urandom;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // leading bytes are dropped, sync word included
    write_start_skip(32'hFFFF_FFFF);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(ac3hp_pkg::SYNC_HI, 1'b0);
    push_byte(ac3hp_pkg::SYNC_LO, 1'b0);
    repeat (6) push_byte(8'($urandom), 1'b0);
    wait_idle();

    // lowered skip mid-skip, sync word split across the start of the hunt
    write_start_skip(32'd16);
    repeat (5) push_byte(8'($urandom), 1'b0);
    push_byte(ac3hp_pkg::SYNC_HI, 1'b0);
    push_byte(ac3hp_pkg::SYNC_LO, 1'b1);

    push_frame(48'hFFFF_FFFF_FFFF, 0);
    push_frame(48'h0000_0000_0000, 0);
    push_frame({ac3hp_pkg::SYNC_HI, ac3hp_pkg::SYNC_LO, 8'hC0, 8'h5A, 8'h4F, 8'h80}, 0);
    push_byte(ac3hp_pkg::SYNC_HI, 1'b1);
    push_frame({16'h1234, 8'h41, 8'h43, 8'h3F, 8'hFF}, 0);
    push_byte(ac3hp_pkg::SYNC_HI, 1'b1);
    push_byte(8'h55, 1'b1);
    push_frame({16'h8001, 8'h26, 8'h08, 8'h20, 8'h01}, 0);

    // receiver holds off while back to back records pile up
    hold_request = 1'b1;
    repeat (8) begin
      push_frame({16'($urandom), ac3hp_pkg::FS_RESERVED, 6'($urandom), 24'($urandom)}, 0);
    end

    for (int ph = 0; ph < 5; ph++) begin
      if (ph > 0) begin
        wait_idle();
        write_start_skip(skip_values[ph]);
      end
      case (ph)
        1: begin send_idle_pct = 52; stall_pct = 0; end
        2: begin send_idle_pct = 0; stall_pct = 52; end
        3: begin send_idle_pct = 36; stall_pct = 36; end
        default: begin send_idle_pct = 0; stall_pct = 0; end
      endcase
      word_goal = counted_bytes + 40;
      frame_goal = frames_built + 4;
      while (counted_bytes < word_goal || frames_built < frame_goal) push_random_sequence();
    end

    wait_idle();
    repeat (16) @(posedge clk);
    $display("stream words sent: %0d over %0d start skip settings, header records checked: %0d",
             bytes_taken, skip_settings, records_seen);
    $display("pacing: free flow, sender gaps, receiver stalls, both, and a %0d cycle hold-off",
             HOLD_CYCLES);
    if (mismatches == 0 && headers_due.size() == 0) begin
      $display("ac3_sync_header_parser_core: match");
    end else begin
      $display("ac3_sync_header_parser_core: mismatch");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("ac3_sync_header_parser_core: mismatch");
    $finish;
  end

endmodule
